// ----- rtl/multichannel_fir_with_passthrough_defines.svh -----
// Assertion macros shared by the filter RTL.
// Depends on nothing; include guarded.
`ifndef MULTICHANNEL_FIR_WITH_PASSTHROUGH_DEFINES_SVH
`define MULTICHANNEL_FIR_WITH_PASSTHROUGH_DEFINES_SVH

// Same-cycle implication under synchronous reset.
`define MCFIR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcfir: same-cycle check failed");

// Next-cycle implication under synchronous reset.
`define MCFIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcfir: next-cycle check failed");

`endif

// ----- rtl/mcfir_pkg.sv -----
// Shared constants, types and coefficient selection for the multichannel FIR.
// No dependencies.
`timescale 1ns / 1ps

package mcfir_pkg;

  localparam int MAX_TAPS       = 8;
  localparam int NUM_CHANNELS   = 16;
  localparam int COEF_FRAC      = 14;
  localparam int SAMPLE_W       = 32;
  localparam int COEF_W         = 16;
  localparam int CH_W           = 4;
  localparam int CFG_W          = 64;
  localparam int CFG_IDX_W      = 2;
  localparam int TAPCNT_W       = 4;
  localparam int COEFS_PER_WORD = CFG_W / COEF_W;
  localparam int TAP_W          = $clog2(MAX_TAPS);
  localparam int SLOT_W         = $clog2(NUM_CHANNELS);
  localparam int ROW_W          = MAX_TAPS * SAMPLE_W;
  localparam int PROD_W         = SAMPLE_W + COEF_W;
  localparam int ACC_W          = PROD_W + TAP_W;
  localparam int Q_W            = ACC_W - COEF_FRAC;
  localparam int USER_OUT_W     = 8;
  localparam int SAT_BIT        = CH_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COEFFS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFFS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_MASK    = 2'd3;

  typedef struct packed {
    logic                start;
    logic [TAPCNT_W-1:0] taps;
  } mac_ctrl_t;

  typedef struct packed {
    logic                       done;
    logic                       sat;
    logic signed [SAMPLE_W-1:0] value;
  } mac_res_t;

  // Signed Q2.14 coefficient of one tap; taps past both words read as zero.
  function automatic logic signed [COEF_W-1:0] coef_of(
    input logic [CFG_W-1:0] lo,
    input logic [CFG_W-1:0] hi,
    input logic [TAP_W-1:0] tap
  );
    logic [CFG_W-1:0] word;
    logic [1:0]       sub;
    word = (int'(tap) < COEFS_PER_WORD) ? lo : hi;
    sub  = tap[1:0];
    if (int'(tap) >= 2 * COEFS_PER_WORD) begin
      return '0;
    end
    return word[sub*COEF_W +: COEF_W];
  endfunction

endpackage

// ----- rtl/multichannel_fir_with_passthrough.sv -----
// Top level of the multichannel FIR with integer-channel passthrough.
// Depends on mcfir_pkg, mcfir_mac and multichannel_fir_with_passthrough_defines.svh.
`timescale 1ns / 1ps
`include "multichannel_fir_with_passthrough_defines.svh"

// Usage:
//   Slave stream: s_tuser carries the channel, s_tdata the signed sample. Each
//   transfer yields exactly one master-stream transfer: m_tdata is the filtered
//   value, m_tuser holds the channel and the saturation flag.
//   Each channel keeps its last MAX_TAPS samples as one row of a history memory
//   (one row per channel, registered read). An item reads its row,
//   shifts the new sample in, writes the row back and then runs the taps one at
//   a time through a single 32x16 multiplier with an accumulator.
//   Filtered channel: the next transfer in waits for the tap-serial
//   multiply-accumulate loop to finish and its result to reach the output register.
//   Integer channel: the sample is returned as is; history still moves.
//   Output: m_tvalid rises once the item has passed the READ, MAC (filtered
//   channels only) and OUT states, when the output register is free.
//   One item is in work at a time; a finished result sits in the output
//   register, so the next sample is taken while it waits for the receiver.
//   If the receiver stalls with a result still held, the block holds its new
//   result until the output register frees, and accepts nothing meanwhile.
//   Reset: synchronous; clears per-row valid bits, so every history reads zero,
//   restores tap_count to 1 and the other registers to zero. No clearing pass.
//   Configuration: cfg_ready is always high; write only while the block is idle.
module multichannel_fir_with_passthrough (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [mcfir_pkg::SAMPLE_W-1:0]   s_tdata,   // [31:0] sample
  input  logic [mcfir_pkg::CH_W-1:0]       s_tuser,   // [3:0] channel
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mcfir_pkg::SAMPLE_W-1:0]   m_tdata,   // [31:0] filtered
  output logic [mcfir_pkg::USER_OUT_W-1:0] m_tuser,   // [3:0] out_channel, [4] saturated
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mcfir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcfir_pkg::CFG_W-1:0]      cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_MAC  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // Configuration registers
  logic [mcfir_pkg::CFG_W-1:0]        coeffs_low;
  logic [mcfir_pkg::CFG_W-1:0]        coeffs_high;
  logic [mcfir_pkg::TAPCNT_W-1:0]     tap_count;
  logic [mcfir_pkg::NUM_CHANNELS-1:0] integer_channel_mask;
  logic [mcfir_pkg::TAPCNT_W-1:0]     taps_eff;

  // History memory: one row per channel, tap 0 (newest) in the low bits
  logic [mcfir_pkg::ROW_W-1:0]        hist_mem [mcfir_pkg::NUM_CHANNELS];
  logic [mcfir_pkg::NUM_CHANNELS-1:0] row_valid;
  logic [mcfir_pkg::ROW_W-1:0]        rd_data;
  logic                               rd_valid;
  logic [mcfir_pkg::ROW_W-1:0]        row_old;
  logic [mcfir_pkg::ROW_W-1:0]        row_new;
  logic                               hist_we;

  logic [1:0]                         state;
  logic [mcfir_pkg::CH_W-1:0]         cur_ch;
  logic [mcfir_pkg::SLOT_W-1:0]       cur_slot;
  logic [mcfir_pkg::SLOT_W-1:0]       in_slot;
  logic [mcfir_pkg::SAMPLE_W-1:0]     cur_smp;
  logic                               bypass;
  logic [mcfir_pkg::SAMPLE_W-1:0]     res_value;
  logic                               res_sat;
  logic                               out_free;
  logic                               s_accept;

  logic [mcfir_pkg::SAMPLE_W-1:0]     out_data;
  logic [mcfir_pkg::CH_W-1:0]         out_ch;
  logic                               out_sat;
  logic                               out_at_limit;

  mcfir_pkg::mac_ctrl_t               mac_ctrl;
  mcfir_pkg::mac_res_t                mac_res;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign in_slot   = mcfir_pkg::SLOT_W'(s_tuser % mcfir_pkg::NUM_CHANNELS);
  assign out_free  = !m_tvalid || m_tready;
  assign bypass    = integer_channel_mask[cur_ch];

  // Zero means one tap; anything past the tap store clamps to its depth
  always_comb begin
    if (tap_count == '0) begin
      taps_eff = mcfir_pkg::TAPCNT_W'(1);
    end else if (int'(tap_count) > mcfir_pkg::MAX_TAPS) begin
      taps_eff = mcfir_pkg::TAPCNT_W'(mcfir_pkg::MAX_TAPS);
    end else begin
      taps_eff = tap_count;
    end
  end

  // Unwritten rows read as zero; shift the new sample in at tap 0
  assign row_old = rd_valid ? rd_data : '0;
  assign row_new = {row_old[mcfir_pkg::ROW_W-mcfir_pkg::SAMPLE_W-1:0], cur_smp};
  assign hist_we = (state == ST_READ);

  assign mac_ctrl.start = (state == ST_READ) && !bypass;
  assign mac_ctrl.taps  = taps_eff;

  mcfir_mac u_mac (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (mac_ctrl),
    .row         (row_new),
    .coeffs_low  (coeffs_low),
    .coeffs_high (coeffs_high),
    .res         (mac_res)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coeffs_low           <= '0;
      coeffs_high          <= '0;
      tap_count            <= mcfir_pkg::TAPCNT_W'(1);
      integer_channel_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mcfir_pkg::CFG_COEFFS_LOW:  coeffs_low  <= cfg_data;
        mcfir_pkg::CFG_COEFFS_HIGH: coeffs_high <= cfg_data;
        mcfir_pkg::CFG_TAP_COUNT:   tap_count   <= cfg_data[mcfir_pkg::TAPCNT_W-1:0];
        mcfir_pkg::CFG_INT_MASK: begin
          integer_channel_mask <= cfg_data[mcfir_pkg::NUM_CHANNELS-1:0];
        end
        default: ;
      endcase
    end
  end

  // History memory: read on transfer in, write back in the cycle after.
  // Only one item is in work, so a read never overlaps a pending write.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      rd_data <= hist_mem[in_slot];
    end
    if (hist_we) begin
      hist_mem[cur_slot] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (hist_we) begin
      row_valid[cur_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      rd_valid <= row_valid[in_slot];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= bypass ? ST_OUT : ST_MAC;
        end
        ST_MAC: begin
          if (mac_res.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item payload and the result waiting for the output register
  always_ff @(posedge clk) begin
    if (s_accept) begin
      cur_ch   <= s_tuser;
      cur_slot <= in_slot;
      cur_smp  <= s_tdata;
    end
    if (state == ST_READ && bypass) begin
      res_value <= cur_smp;
      res_sat   <= 1'b0;
    end else if (state == ST_MAC && mac_res.done) begin
      res_value <= mac_res.value;
      res_sat   <= mac_res.sat;
    end
  end

  // Output register: drop valid once taken, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_data <= res_value;
      out_ch   <= cur_ch;
      out_sat  <= res_sat;
    end
  end

  assign m_tdata = out_data;
  assign m_tuser = {{(mcfir_pkg::USER_OUT_W-mcfir_pkg::CH_W-1){1'b0}}, out_sat, out_ch};

  assign out_at_limit = (m_tdata == {1'b1, {(mcfir_pkg::SAMPLE_W-1){1'b0}}}) ||
                        (m_tdata == {1'b0, {(mcfir_pkg::SAMPLE_W-1){1'b1}}});

  // A clipped result is always one of the two 32-bit extremes
  `MCFIR_ASSERT_NOW(a_sat_extreme, clk, rst, m_tvalid && m_tuser[mcfir_pkg::SAT_BIT], out_at_limit)
  // The accumulator finishes only while the sequencer waits for it
  `MCFIR_ASSERT_NOW(a_mac_done_in_mac, clk, rst, mac_res.done, state == ST_MAC)
  // A transfer in always moves on to the history read-modify-write
  `MCFIR_ASSERT_NEXT(a_accept_reads, clk, rst, s_accept, state == ST_READ && hist_we)

endmodule

// ----- rtl/mcfir_mac.sv -----
// Tap-serial multiply-accumulate with floor shift and 32-bit saturation.
// Depends on mcfir_pkg.
`timescale 1ns / 1ps

module mcfir_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  mcfir_pkg::mac_ctrl_t         ctrl,
  input  logic [mcfir_pkg::ROW_W-1:0]  row,
  input  logic [mcfir_pkg::CFG_W-1:0]  coeffs_low,
  input  logic [mcfir_pkg::CFG_W-1:0]  coeffs_high,
  output mcfir_pkg::mac_res_t          res
);

  logic [mcfir_pkg::ROW_W-1:0]           row_q;
  logic [mcfir_pkg::TAPCNT_W-1:0]        taps;
  logic [mcfir_pkg::TAPCNT_W-1:0]        idx;
  logic                                  busy;
  logic                                  prod_valid;
  logic signed [mcfir_pkg::PROD_W-1:0]   prod;
  logic signed [mcfir_pkg::ACC_W-1:0]    acc;
  logic                                  issue;
  logic [mcfir_pkg::TAP_W-1:0]           tap;
  logic signed [mcfir_pkg::SAMPLE_W-1:0] hist;
  logic signed [mcfir_pkg::COEF_W-1:0]   coef;
  logic signed [mcfir_pkg::PROD_W-1:0]   prod_next;
  logic signed [mcfir_pkg::Q_W-1:0]      q;
  logic                                  overflow;

  assign issue     = busy && (idx < taps);
  assign tap       = idx[mcfir_pkg::TAP_W-1:0];
  assign hist      = row_q[tap*mcfir_pkg::SAMPLE_W +: mcfir_pkg::SAMPLE_W];
  assign coef      = mcfir_pkg::coef_of(coeffs_low, coeffs_high, tap);
  assign prod_next = hist * coef;

  // Floor shift, then clip when the sign of a 32-bit word and the bits above it disagree
  assign q        = acc[mcfir_pkg::ACC_W-1:mcfir_pkg::COEF_FRAC];
  assign overflow = !((&q[mcfir_pkg::Q_W-1:mcfir_pkg::SAMPLE_W-1]) ||
                      !(|q[mcfir_pkg::Q_W-1:mcfir_pkg::SAMPLE_W-1]));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      prod_valid <= 1'b0;
      res.done   <= 1'b0;
    end else begin
      res.done <= 1'b0;
      if (ctrl.start) begin
        busy       <= 1'b1;
        prod_valid <= 1'b0;
        idx        <= '0;
        acc        <= '0;
        taps       <= ctrl.taps;
        row_q      <= row;
      end else if (busy) begin
        prod_valid <= issue;
        if (issue) begin
          prod <= prod_next;
          idx  <= idx + 1'b1;
        end
        if (prod_valid) begin
          acc <= acc + mcfir_pkg::ACC_W'(prod);
        end
        if (!issue && !prod_valid) begin
          busy     <= 1'b0;
          res.done <= 1'b1;
          res.sat  <= overflow;
          if (!overflow) begin
            res.value <= q[mcfir_pkg::SAMPLE_W-1:0];
          end else if (q[mcfir_pkg::Q_W-1]) begin
            res.value <= {1'b1, {(mcfir_pkg::SAMPLE_W-1){1'b0}}};
          end else begin
            res.value <= {1'b0, {(mcfir_pkg::SAMPLE_W-1){1'b1}}};
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/multichannel_fir_with_passthrough_test.sv -----
// Self-checking testbench for the multichannel FIR with integer-channel passthrough.
// Needs mcfir_pkg and the filter RTL. Drives the sample, result and register channels,
// predicts each result and checks it against what the block returns.
`timescale 1ns / 1ps

module multichannel_fir_with_passthrough_test;
  import mcfir_pkg::*;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  TAIL_CYCLES = 40;      // well past the worst case per item
  localparam int  LONG_HOLD   = 400;     // receiver hold-off that backs the block up
  localparam int  MAX_REPORTS = 40;
  localparam int  RAND_PHASES = 8;
  localparam int  PHASE_ITEMS = 100;
  localparam longint CLIP_HI  = 64'sd2147483647;
  localparam longint CLIP_LO  = -64'sd2147483648;

  typedef struct packed {
    logic [CH_W-1:0]     chan;
    logic [SAMPLE_W-1:0] sample;
  } fir_sample_t;

  typedef struct packed {
    logic [CH_W-1:0]     chan;
    logic [SAMPLE_W-1:0] value;
    logic                sat;
  } fir_result_t;

  // DUT ports; the inputs are all known from time zero
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata   = '0;
  logic [CH_W-1:0]       s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [SAMPLE_W-1:0]   m_tdata;
  logic [USER_OUT_W-1:0] m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data  = '0;

  // Shadow of the register file, at reset values
  logic [CFG_W-1:0]      cfg_coeffs_low  = '0;
  logic [CFG_W-1:0]      cfg_coeffs_high = '0;
  logic [TAPCNT_W-1:0]   cfg_tap_count   = 4'd1;
  logic [15:0]           cfg_int_mask    = '0;

  // Per-channel sample history, newest at index 0
  logic signed [SAMPLE_W-1:0] chan_history [NUM_CHANNELS][MAX_TAPS] = '{default: '0};

  fir_sample_t samples_pending[$];
  fir_result_t expected_results[$];

  int burst_left    = 1;
  int gap_left      = 0;
  int rx_left       = 0;
  logic rx_stall    = 1'b0;
  int hold_left     = 0;
  int holds_asked   = 0;
  int holds_served  = 0;
  int cycle_count   = 0;
  int failures      = 0;
  int samples_taken = 0;
  int results_seen  = 0;
  int bypass_count  = 0;
  int clipped_count = 0;

  multichannel_fir_with_passthrough i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Shift the sample into its channel history and work out the result it yields.
  function automatic fir_result_t filter_sample(input logic [CH_W-1:0] chan,
                                                input logic [SAMPLE_W-1:0] sample);
    fir_result_t res;
    longint acc;
    longint q;
    int unsigned taps;
    logic signed [COEF_W-1:0] coef;
    acc = 0;
    for (int t = MAX_TAPS - 1; t > 0; t--) begin
      chan_history[chan][t] = chan_history[chan][t-1];
    end
    chan_history[chan][0] = sample;
    // zero taps behaves as one, anything above eight is clamped
    if (cfg_tap_count == 0) begin
      taps = 1;
    end else if (cfg_tap_count > MAX_TAPS) begin
      taps = MAX_TAPS;
    end else begin
      taps = cfg_tap_count;
    end
    res.chan  = chan;
    res.value = sample;
    res.sat   = 1'b0;
    if (cfg_int_mask[chan]) begin
      bypass_count++;
      return res;
    end
    for (int t = 0; t < taps; t++) begin
      if (t < COEFS_PER_WORD) begin
        coef = cfg_coeffs_low[COEF_W*t +: COEF_W];
      end else begin
        coef = cfg_coeffs_high[COEF_W*(t-COEFS_PER_WORD) +: COEF_W];
      end
      acc += longint'(chan_history[chan][t]) * longint'(coef);
    end
    q = acc >>> COEF_FRAC;   // floor, not truncation towards zero
    if (q > CLIP_HI) begin
      q = CLIP_HI;
      res.sat = 1'b1;
    end else if (q < CLIP_LO) begin
      q = CLIP_LO;
      res.sat = 1'b1;
    end
    if (res.sat) clipped_count++;
    res.value = q[SAMPLE_W-1:0];
    return res;
  endfunction

  // Sample source: bursts of random length with random gaps. Predict on each transfer.
  always @(posedge clk) begin
    logic next_valid;
    fir_sample_t item;
    next_valid = s_tvalid;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(filter_sample(s_tuser, s_tdata));
        samples_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (samples_pending.size() > 0) begin
          item = samples_pending.pop_front();
          s_tdata <= item.sample;
          s_tuser <= item.chan;
          next_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    s_tvalid <= next_valid;
  end

  // Result sink: alternating ready and stall runs, plus the odd long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (rx_left > 0) begin
        rx_left--;
      end else begin
        rx_stall = !rx_stall;
        rx_left  = rx_stall ? $urandom_range(0, 9) : $urandom_range(0, 30);
      end
      m_tready <= !rx_stall;
    end
  end

  // Compare each result transfer with the oldest expectation; also run the watchdog.
  always @(posedge clk) begin
    fir_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               expected_results.size());
      $display("FAIL multichannel_fir_with_passthrough");
      $finish;
    end else if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: result with nothing expected, expected none actual ch %0d data %h",
                   $time, m_tuser[CH_W-1:0], m_tdata);
      end else begin
        want = expected_results.pop_front();
        if (m_tuser[CH_W-1:0] !== want.chan) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("%0t: out_channel mismatch, expected %0d actual %0d", $time,
                     want.chan, m_tuser[CH_W-1:0]);
        end
        if (m_tdata !== want.value) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("%0t: filtered mismatch on ch %0d, expected %h actual %h", $time,
                     want.chan, want.value, m_tdata);
        end
        if (m_tuser[SAT_BIT] !== want.sat) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("%0t: saturated mismatch on ch %0d, expected %b actual %b", $time,
                     want.chan, want.sat, m_tuser[SAT_BIT]);
        end
      end
    end
  end

  // Call at a rising edge; leaves cfg_valid high so writes can run back to back.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_COEFFS_LOW:  cfg_coeffs_low  = value;
      CFG_COEFFS_HIGH: cfg_coeffs_high = value;
      CFG_TAP_COUNT:   cfg_tap_count   = value[TAPCNT_W-1:0];
      CFG_INT_MASK:    cfg_int_mask    = value[15:0];
      default: ;
    endcase
  endtask

  // Only called once the block has drained.
  task automatic load_settings(input logic [CFG_W-1:0] coeffs_lo,
                               input logic [CFG_W-1:0] coeffs_hi,
                               input logic [CFG_W-1:0] taps,
                               input logic [CFG_W-1:0] mask);
    @(posedge clk);
    write_register(CFG_COEFFS_LOW, coeffs_lo);
    write_register(CFG_COEFFS_HIGH, coeffs_hi);
    write_register(CFG_TAP_COUNT, taps);
    write_register(CFG_INT_MASK, mask);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_sample(input logic [CH_W-1:0] chan, input logic [SAMPLE_W-1:0] s);
    fir_sample_t item;
    item.chan   = chan;
    item.sample = s;
    samples_pending.push_back(item);
  endtask

  // Settle on the falling edge so the driver's and monitor's updates are all visible.
  task automatic wait_drained();
    do @(negedge clk);
    while (samples_pending.size() != 0 || s_tvalid || expected_results.size() != 0);
  endtask

  function automatic logic [CFG_W-1:0] pick_coeffs();
    logic [CFG_W-1:0] word;
    for (int lane = 0; lane < COEFS_PER_WORD; lane++) begin
      case ($urandom_range(0, 5))
        0:       word[COEF_W*lane +: COEF_W] = 16'h7FFF;
        1:       word[COEF_W*lane +: COEF_W] = 16'h8000;
        2:       word[COEF_W*lane +: COEF_W] = 16'h0000;
        3:       word[COEF_W*lane +: COEF_W] = 16'hFFFF;
        default: word[COEF_W*lane +: COEF_W] = COEF_W'($urandom_range(0, 16'hFFFF));
      endcase
    end
    return word;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 2000) - 1000;
      3:       return 32'h7FFF_0000 | $urandom_range(0, 16'hFFFF);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] taps_word;
    logic [CFG_W-1:0] mask_word;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one tap with a zero coefficient, empty histories
    queue_sample(4'd0, 32'h7FFF_FFFF);
    queue_sample(4'd15, 32'h8000_0000);
    queue_sample(4'd7, 32'hFFFF_FFFF);
    wait_drained();

    // Largest positive coefficients on all eight taps: drive both clip limits
    load_settings(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF, 64'd8, 64'h0001);
    queue_sample(4'd0, 32'h8000_0000);     // integer channel, raw sample back
    queue_sample(4'd0, 32'h7FFF_FFFF);
    repeat (3) queue_sample(4'd3, 32'h7FFF_FFFF);
    repeat (2) queue_sample(4'd4, 32'h8000_0000);
    queue_sample(4'd5, 32'h0000_0001);
    queue_sample(4'd5, 32'hFFFF_FFFF);     // the two samples cancel to zero
    queue_sample(4'd9, 32'h1234_5678);
    wait_drained();

    // Tap count zero acts as one; tap 0 is -2.0, so both extremes clip
    load_settings(64'h0001_FFFF_4000_8000, 64'hC000_2000_0001_7FFF, 64'd0, 64'h8000);
    queue_sample(4'd15, 32'h8000_0000);
    queue_sample(4'd6, 32'h7FFF_FFFF);
    queue_sample(4'd6, 32'h8000_0000);
    queue_sample(4'd2, 32'h0000_0003);
    wait_drained();

    // Tap count above eight clamps to eight; mixed coefficients over older history
    load_settings(64'h0001_FFFF_4000_8000, 64'hC000_2000_0001_7FFF, 64'd15, 64'h7FFE);
    queue_sample(4'd0, 32'h4000_0000);
    queue_sample(4'd1, 32'hDEAD_BEEF);
    queue_sample(4'd0, 32'hC000_0001);
    queue_sample(4'd6, 32'h0000_4000);
    wait_drained();

    // Random phases; each ends with the source paused until every result is back
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 2))
        0:       taps_word = CFG_W'($urandom_range(0, 15));
        default: taps_word = CFG_W'($urandom_range(1, 8));
      endcase
      if (p == 0) taps_word = CFG_W'(8);
      if ($urandom_range(0, 1)) begin
        taps_word[CFG_W-1:TAPCNT_W] = (CFG_W-TAPCNT_W)'({$urandom, $urandom});
      end
      case (p % 4)
        0:       mask_word = 64'h0000;
        1:       mask_word = 64'hFFFF;
        default: mask_word = CFG_W'($urandom_range(0, 16'hFFFF));
      endcase
      if ($urandom_range(0, 1)) mask_word[CFG_W-1:16] = (CFG_W-16)'({$urandom, $urandom});
      if (p % 3 == 2) begin
        load_settings({$urandom, $urandom}, {$urandom, $urandom}, taps_word, mask_word);
      end else begin
        load_settings(pick_coeffs(), pick_coeffs(), taps_word, mask_word);
      end
      // Hold the result side off so the block fills and stalls its input
      if (p == 2 || p == 5) holds_asked++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // odd phases crowd a few channels to build deep histories
        queue_sample(CH_W'((p % 2) ? $urandom_range(0, 3) : $urandom_range(0, 15)),
                     pick_sample());
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      failures++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end
    $display("Covered %0d samples and %0d results over %0d register settings,",
             samples_taken, results_seen, RAND_PHASES + 4);
    $display("with %0d passthrough, %0d clipped, %0d long receiver hold-offs.",
             bypass_count, clipped_count, holds_served);
    if (failures == 0) begin
      $display("PASS multichannel_fir_with_passthrough");
    end else begin
      $display("FAIL multichannel_fir_with_passthrough");
    end
    $finish;
  end

endmodule
